### sv/btse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package btse_pkg;

	localparam int TABLE_ENTRIES = 4096;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int SYMBOL_WIDTH  = 16;
	localparam int QUEUE_DEPTH   = 4;

	localparam int CFG_ADDR_W    = 3;
	localparam int CFG_DATA_W    = 32;
	localparam int REG_SEL_BIT   = 2;

	localparam logic REG_MARKER_ONE = 1'b0;
	localparam logic REG_MARKER_TWO = 1'b1;

	localparam logic [15:0] MARKER_ONE_RESET = 16'd20063;
	localparam logic [15:0] MARKER_TWO_RESET = 16'd21705;

	localparam logic KIND_TABLE = 1'b0;
	localparam logic KIND_DATA  = 1'b1;

	localparam logic [1:0] PAD_NONE = 2'd0;
	localparam logic [1:0] PAD_ONE  = 2'd1;
	localparam logic [1:0] PAD_TWO  = 2'd2;

	typedef struct packed {
		logic        kind;
		logic [11:0] table_index;
		logic [15:0] table_value;
		logic [7:0]  data_byte;
		logic        last_byte;
	} in_item_t;

	typedef struct packed {
		logic [15:0] symbol;
		logic        last_symbol;
	} out_item_t;

	typedef struct packed {
		logic [1:0] pads;
		logic       last;
	} grp_ctl_t;

endpackage
`default_nettype wire

### sv/btse_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module btse_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr0,
	input  wire logic [$clog2(DEPTH)-1:0] raddr1,
	output logic      [WIDTH-1:0]         rdata0_q,
	output logic      [WIDTH-1:0]         rdata1_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata0_q <= mem_q[raddr0];
			rdata1_q <= mem_q[raddr1];
		end
	end

endmodule
`default_nettype wire

### sv/btse_front.sv
`timescale 1ns / 1ps
`default_nettype none
module btse_front #(
	parameter int SYMBOL_WIDTH = btse_pkg::SYMBOL_WIDTH,
	parameter int QUEUE_DEPTH  = btse_pkg::QUEUE_DEPTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                item_valid,
	output logic                                     item_ready,
	input  wire btse_pkg::in_item_t                  item,
	input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]    fifo_level,
	output logic                                     push,
	output logic      [2*SYMBOL_WIDTH-1:0]           push_data,
	output btse_pkg::grp_ctl_t                       push_ctl
);

	localparam int LVL_W = $clog2(QUEUE_DEPTH+1);

	logic [15:0]             held_bytes_q;
	logic [1:0]              held_count_q;
	logic                    grp_valid_s1;
	btse_pkg::grp_ctl_t      ctl_s1;
	logic [23:0]             group;
	logic                    accept;
	logic                    is_data;
	logic                    close;
	logic [LVL_W:0]          busy;
	logic [SYMBOL_WIDTH-1:0] sym_hi;
	logic [SYMBOL_WIDTH-1:0] sym_lo;

	assign busy       = (LVL_W+1)'(fifo_level) + (LVL_W+1)'(grp_valid_s1);
	assign item_ready = busy < (LVL_W+1)'(QUEUE_DEPTH);
	assign accept     = item_valid && item_ready;
	assign is_data    = item.kind == btse_pkg::KIND_DATA;
	assign close      = is_data && (held_count_q == 2'd2 || item.last_byte);

	always_comb begin
		case (held_count_q)
			2'd0: group = {16'h0000, item.data_byte};
			2'd1: group = {8'h00, item.data_byte, held_bytes_q[7:0]};
			default: group = {item.data_byte, held_bytes_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bytes_q <= '0;
			held_count_q <= '0;
			grp_valid_s1 <= 1'b0;
		end else begin
			grp_valid_s1 <= accept && close;
			if (accept && is_data) begin
				if (close) begin
					held_bytes_q <= '0;
					held_count_q <= '0;
				end else begin
					held_bytes_q <= group[15:0];
					held_count_q <= held_count_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && close) begin
			ctl_s1.pads <= btse_pkg::PAD_TWO - held_count_q;
			ctl_s1.last <= item.last_byte;
		end
	end

	btse_ram #(
		.WIDTH (SYMBOL_WIDTH),
		.DEPTH (btse_pkg::TABLE_ENTRIES)
	) u_table (
		.clk      (clk),
		.we       (accept && item.kind == btse_pkg::KIND_TABLE),
		.waddr    (item.table_index),
		.wdata    (SYMBOL_WIDTH'(item.table_value)),
		.re       (accept && close),
		.raddr0   (group[23:12]),
		.raddr1   (group[11:0]),
		.rdata0_q (sym_hi),
		.rdata1_q (sym_lo)
	);

	assign push      = grp_valid_s1;
	assign push_data = {sym_hi, sym_lo};
	assign push_ctl  = ctl_s1;

endmodule
`default_nettype wire

### sv/btse_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module btse_fifo #(
	parameter int WIDTH = 35,
	parameter int DEPTH = btse_pkg::QUEUE_DEPTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           push_data,
	input  wire logic                       pop,
	output logic                            head_valid,
	output logic      [WIDTH-1:0]           head_data,
	output logic      [$clog2(DEPTH+1)-1:0] level
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int LVL_W = $clog2(DEPTH+1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10: level_q <= level_q + LVL_W'(1);
				2'b01: level_q <= level_q - LVL_W'(1);
				default: level_q <= level_q;
			endcase
		end
	end

	assign head_valid = level_q != '0;
	assign head_data  = entry_q[rd_ptr_q];
	assign level      = level_q;

endmodule
`default_nettype wire

### sv/btse_back.sv
`timescale 1ns / 1ps
`default_nettype none
module btse_back #(
	parameter int SYMBOL_WIDTH = btse_pkg::SYMBOL_WIDTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      head_valid,
	input  wire logic [2*SYMBOL_WIDTH-1:0] head_data,
	input  wire btse_pkg::grp_ctl_t        head_ctl,
	output logic                           pop,
	input  wire logic [15:0]               marker_one,
	input  wire logic [15:0]               marker_two,
	output logic                           sym_valid,
	input  wire logic                      sym_ready,
	output btse_pkg::out_item_t            sym
);

	localparam logic [1:0] PH_HI   = 2'd0;
	localparam logic [1:0] PH_LO   = 2'd1;
	localparam logic [1:0] PH_MARK = 2'd2;

	logic [1:0]          phase_q;
	logic                out_valid_q;
	btse_pkg::out_item_t out_q;
	btse_pkg::out_item_t beat;
	logic                final_beat;
	logic                load;

	always_comb begin
		beat       = '0;
		final_beat = 1'b1;
		unique case (phase_q)
			PH_HI: begin
				beat.symbol      = 16'(head_data[2*SYMBOL_WIDTH-1:SYMBOL_WIDTH]);
				beat.last_symbol = 1'b0;
				final_beat       = 1'b0;
			end
			PH_LO: begin
				beat.symbol      = 16'(head_data[SYMBOL_WIDTH-1:0]);
				final_beat       = head_ctl.pads == btse_pkg::PAD_NONE;
				beat.last_symbol = final_beat && head_ctl.last;
			end
			PH_MARK: begin
				if (head_ctl.pads == btse_pkg::PAD_TWO) begin
					beat.symbol = 16'(SYMBOL_WIDTH'(marker_two));
				end else begin
					beat.symbol = 16'(SYMBOL_WIDTH'(marker_one));
				end
				beat.last_symbol = 1'b1;
			end
			default: begin
				beat       = '0;
				final_beat = 1'b1;
			end
		endcase
	end

	assign load = head_valid && (!out_valid_q || sym_ready);
	assign pop  = load && final_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HI;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= final_beat ? PH_HI : phase_q + 2'd1;
			end else if (sym_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= beat;
		end
	end

	assign sym_valid = out_valid_q;
	assign sym       = out_q;

endmodule
`default_nettype wire

### sv/byte_triplet_table_symbol_encoder.sv
// byte triplet table symbol encoder
// item channel (item_valid / item_ready / item): one beat per cycle while ready;
// kind selects a table write or a message byte. table writes go straight into the
// 4096-entry symbol ram and give no output; load the table before sending data.
// bytes are grouped in threes, little-endian; each group gives two symbols
// (table entry at bits 23..12, then at bits 11..0). last_byte closes a partial
// group with zero padding and adds a marker symbol (one-pad or two-pad).
// sym channel (sym_valid / sym_ready / sym): one beat per cycle while ready,
// last_symbol on the final beat of a message.
// throughput: one byte per cycle while item_ready is high, one symbol per cycle
// while sym_ready is high; the symbol side is set by the single output register.
// a 4-entry group queue sits between the byte side and the symbol side; when
// the receiver stalls it fills and item_ready falls, nothing is lost.
// apb registers: 0x0 marker_one_pad, 0x4 marker_two_pad; write only while idle.
// reset clears the byte grouping, queue and output beat and sets the markers to
// their reset values; the table keeps no reset and must be written before use.
`timescale 1ns / 1ps
`default_nettype none
module byte_triplet_table_symbol_encoder #(
	parameter int SYMBOL_WIDTH = btse_pkg::SYMBOL_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_valid,
	output logic                                 item_ready,
	input  wire btse_pkg::in_item_t              item,
	output logic                                 sym_valid,
	input  wire logic                            sym_ready,
	output btse_pkg::out_item_t                  sym,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [btse_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [btse_pkg::CFG_DATA_W-1:0] pwdata,
	output logic      [btse_pkg::CFG_DATA_W-1:0] prdata,
	output logic                                 pready
);

	localparam int QD     = btse_pkg::QUEUE_DEPTH;
	localparam int ENTRY_W = 2*SYMBOL_WIDTH + $bits(btse_pkg::grp_ctl_t);

	logic [15:0]                 marker_one_q;
	logic [15:0]                 marker_two_q;
	logic                        cfg_write;
	logic                        reg_sel;
	logic                        push;
	logic [2*SYMBOL_WIDTH-1:0]   push_data;
	btse_pkg::grp_ctl_t          push_ctl;
	logic                        pop;
	logic                        head_valid;
	logic [ENTRY_W-1:0]          head_entry;
	btse_pkg::grp_ctl_t          head_ctl;
	logic [$clog2(QD+1)-1:0]     fifo_level;

	assign pready    = 1'b1;
	assign reg_sel   = paddr[btse_pkg::REG_SEL_BIT];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_one_q <= btse_pkg::MARKER_ONE_RESET;
			marker_two_q <= btse_pkg::MARKER_TWO_RESET;
		end else if (cfg_write) begin
			unique case (reg_sel)
				btse_pkg::REG_MARKER_ONE: marker_one_q <= pwdata[15:0];
				btse_pkg::REG_MARKER_TWO: marker_two_q <= pwdata[15:0];
				default: marker_one_q <= marker_one_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			btse_pkg::REG_MARKER_ONE: prdata = btse_pkg::CFG_DATA_W'(marker_one_q);
			btse_pkg::REG_MARKER_TWO: prdata = btse_pkg::CFG_DATA_W'(marker_two_q);
			default: prdata = '0;
		endcase
	end

	btse_front #(
		.SYMBOL_WIDTH (SYMBOL_WIDTH),
		.QUEUE_DEPTH  (QD)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.fifo_level (fifo_level),
		.push       (push),
		.push_data  (push_data),
		.push_ctl   (push_ctl)
	);

	btse_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (QD)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({push_ctl, push_data}),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_entry),
		.level      (fifo_level)
	);

	assign head_ctl = head_entry[ENTRY_W-1:2*SYMBOL_WIDTH];

	btse_back #(
		.SYMBOL_WIDTH (SYMBOL_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_entry[2*SYMBOL_WIDTH-1:0]),
		.head_ctl   (head_ctl),
		.pop        (pop),
		.marker_one (marker_one_q),
		.marker_two (marker_two_q),
		.sym_valid  (sym_valid),
		.sym_ready  (sym_ready),
		.sym        (sym)
	);

endmodule
`default_nettype wire

### sim/byte_triplet_table_symbol_encoder_tb.sv
`timescale 1ns / 1ps
module byte_triplet_table_symbol_encoder_tb;
	import btse_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_ITEMS   = 84;

	class encoder_predictor;
		logic [15:0] sym_table [TABLE_ENTRIES];
		logic [15:0] held_bytes;
		logic [1:0]  held_count;
		logic [15:0] marker_one;
		logic [15:0] marker_two;
		out_item_t   due_symbols[$];
		int          bad_symbols;

		function new();
			foreach (sym_table[i])
				sym_table[i] = 16'h0000;
			held_bytes  = 16'h0000;
			held_count  = 2'd0;
			marker_one  = MARKER_ONE_RESET;
			marker_two  = MARKER_TWO_RESET;
			bad_symbols = 0;
		endfunction

		function void set_marker(input logic sel, input logic [15:0] value);
			if (sel == REG_MARKER_ONE)
				marker_one = value;
			else
				marker_two = value;
		endfunction

		function void add_symbol(input logic [15:0] value, input logic last);
			out_item_t s;
			s.symbol      = value;
			s.last_symbol = last;
			due_symbols = {due_symbols, s};
		endfunction

		function void take_item(input in_item_t it);
			logic [23:0] grp;
			if (it.kind == KIND_TABLE) begin
				sym_table[it.table_index] = it.table_value;
				return;
			end
			if (held_count < 2'd2 && !it.last_byte) begin
				held_bytes = held_bytes | (16'(it.data_byte) << (8 * held_count));
				held_count = held_count + 2'd1;
				return;
			end
			grp = {8'h00, held_bytes} | (24'(it.data_byte) << (8 * held_count));
			add_symbol(sym_table[grp[23:12]], 1'b0);
			if (held_count == 2'd2) begin
				add_symbol(sym_table[grp[11:0]], it.last_byte);
			end else begin
				add_symbol(sym_table[grp[11:0]], 1'b0);
				add_symbol(held_count == 2'd0 ? marker_two : marker_one, 1'b1);
			end
			held_bytes = 16'h0000;
			held_count = 2'd0;
		endfunction

		function void check_symbol(input out_item_t got);
			out_item_t want;
			if (due_symbols.size() == 0) begin
				bad_symbols++;
				if (bad_symbols <= 10)
					$display("unexpected symbol beat %h last %0b", got.symbol, got.last_symbol);
				return;
			end
			want = due_symbols.pop_front();
			if (got.symbol !== want.symbol || got.last_symbol !== want.last_symbol) begin
				bad_symbols++;
				if (bad_symbols <= 10)
					$display("symbol mismatch: expected %h last %0b, got %h last %0b",
						want.symbol, want.last_symbol, got.symbol, got.last_symbol);
			end
		endfunction
	endclass

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_ready;
	in_item_t              item       = '0;
	logic                  sym_valid;
	logic                  sym_ready  = 1'b0;
	out_item_t             sym;
	logic                  psel       = 1'b0;
	logic                  penable    = 1'b0;
	logic                  pwrite     = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr      = '0;
	logic [CFG_DATA_W-1:0] pwdata     = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	encoder_predictor pred = new();

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;
	int cycle_count = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;

	// generator's own view of the open group, so every lookup hits a loaded entry
	bit          loaded [TABLE_ENTRIES];
	logic [15:0] gen_held = 16'h0000;
	logic [1:0]  gen_count = 2'd0;

	byte_triplet_table_symbol_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.sym_valid(sym_valid),
		.sym_ready(sym_ready),
		.sym(sym),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// symbol side: check each beat, then choose ready for the next cycle
	always @(posedge clk) begin
		if (sym_valid && sym_ready)
			pred.check_symbol(sym);
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			sym_ready <= 1'b0;
		end else begin
			sym_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic push_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		pred.take_item(it);
		items_sent++;
	endtask

	task automatic load_entry(input logic [11:0] idx, input logic [15:0] value);
		in_item_t it;
		it.kind        = KIND_TABLE;
		it.table_index = idx;
		it.table_value = value;
		it.data_byte   = 8'($urandom_range(255));
		it.last_byte   = 1'($urandom_range(1));
		loaded[idx] = 1'b1;
		push_item(it);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		in_item_t    it;
		logic [23:0] grp;
		grp = {8'h00, gen_held} | (24'(b) << (8 * gen_count));
		if (last || gen_count == 2'd2) begin
			if (!loaded[grp[23:12]])
				load_entry(grp[23:12], 16'($urandom_range(65535)));
			if (!loaded[grp[11:0]])
				load_entry(grp[11:0], 16'($urandom_range(65535)));
			gen_held = 16'h0000;
			gen_count = 2'd0;
		end else begin
			gen_held = gen_held | (16'(b) << (8 * gen_count));
			gen_count = gen_count + 2'd1;
		end
		it.kind        = KIND_DATA;
		it.table_index = 12'($urandom_range(4095));
		it.table_value = 16'($urandom_range(65535));
		it.data_byte   = b;
		it.last_byte   = last;
		push_item(it);
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (pred.due_symbols.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_marker(input logic sel, input logic [15:0] value);
		logic [CFG_ADDR_W-1:0] addr;
		addr = '0;
		addr[REG_SEL_BIT] = sel;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= CFG_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		pred.set_marker(sel, value);
		@(posedge clk);
	endtask

	initial begin
		int          n;
		int          target;
		logic [7:0]  b;
		logic        last;
		logic [15:0] one_val;
		logic [15:0] two_val;

		foreach (loaded[i])
			loaded[i] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats with the reset markers
		load_entry(12'h000, 16'h0000);
		load_entry(12'hFFF, 16'hFFFF);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h56, 1'b0);
		send_byte(8'h78, 1'b1);
		send_byte(8'hAB, 1'b0);
		load_entry(12'($urandom_range(4095)), 16'($urandom_range(65535)));
		send_byte(8'hCD, 1'b0);
		send_byte(8'hEF, 1'b1);
		settle();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					one_val = 16'h0000;
					two_val = 16'hFFFF;
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					one_val = 16'hFFFF;
					two_val = 16'h0000;
					send_idle_pct = 83;
					recv_stall_pct = 0;
				end
				2: begin
					one_val = 16'($urandom_range(65535));
					two_val = 16'($urandom_range(65535));
					send_idle_pct = 0;
					recv_stall_pct = 83;
				end
				default: begin
					one_val = 16'($urandom_range(65535));
					two_val = 16'($urandom_range(65535));
					send_idle_pct = 16;
					recv_stall_pct = 16;
				end
			endcase
			write_marker(REG_MARKER_ONE, one_val);
			write_marker(REG_MARKER_TWO, two_val);
			if (p == 0)
				hold_req = 1'b1;
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				n = $urandom_range(1, 9);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(3) == 0)
						b = {8{1'($urandom_range(1))}};
					else
						b = 8'($urandom_range(255));
					last = (i == n - 1) && ($urandom_range(9) != 0);
					if ($urandom_range(9) == 0)
						load_entry(12'($urandom_range(4095)), 16'($urandom_range(65535)));
					send_byte(b, last);
				end
			end
			settle();
		end

		if (pred.bad_symbols == 0 && pred.due_symbols.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
